[src/tmpos_pkg.sv]
// Package for the timed motor positioner: action and drive codes, register
// indexes, default constants and the state and result types. No dependencies.
package tmpos_pkg;

  localparam int unsigned FullStrokeDef   = 20000;
  localparam int unsigned PosW            = 16;
  localparam int unsigned StallW          = 10;
  localparam int unsigned CfgIdxW         = 1;
  localparam int unsigned CfgDataW        = 16;

  localparam logic [StallW-1:0] StallTimeoutRst  = 10'd50;
  localparam logic [PosW-1:0]   EndpointExtRst   = 16'd5000;
  localparam logic [PosW-1:0]   GoalRst          = 16'hFFFF;
  localparam logic [PosW-1:0]   CountMax         = 16'hFFFF;

  // floor(p / 100) == (p * 5243) >> 19 for every p up to 43698
  localparam logic [12:0]       Div100Mul        = 13'd5243;
  localparam int unsigned       Div100Shift      = 19;

  localparam logic [2:0] ACT_TICK   = 3'd0;
  localparam logic [2:0] ACT_HALL   = 3'd1;
  localparam logic [2:0] ACT_MOVE   = 3'd2;
  localparam logic [2:0] ACT_STOP   = 3'd3;
  localparam logic [2:0] ACT_PRESET = 3'd4;

  localparam logic [1:0] MOTION_STOP = 2'd0;
  localparam logic [1:0] MOTION_FWD  = 2'd1;
  localparam logic [1:0] MOTION_BACK = 2'd2;

  localparam logic [CfgIdxW-1:0] CFG_STALL_TIMEOUT = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_ENDPOINT_EXT  = 1'd1;

  typedef struct packed {
    logic [1:0]      motion;
    logic [PosW-1:0] position;
    logic [PosW-1:0] goal;
    logic [PosW-1:0] budget;
    logic [PosW-1:0] elapsed;
    logic [PosW-1:0] gap;
  } tmpos_state_t;

  typedef struct packed {
    logic [1:0]      drive;
    logic [PosW-1:0] position;
    logic            move_done;
    logic            save_strobe;
    logic [PosW-1:0] save_value;
  } tmpos_result_t;

endpackage

[src/timed_motor_positioner.sv]
// Timed motor positioner top level: valid/ready channels, config registers,
// state and result registers. Depends on tmpos_pkg and tmpos_core.
// Throughput: one item per cycle while no result is held or out_ready is high;
// a single update stage sits between the state registers and the result
// register, which frees whenever out_ready is high.
// Reset (rst_n low, synchronous): stopped, position 0, goal all ones, counters 0,
// stall timeout 50, endpoint extension 5000, no result pending.
module timed_motor_positioner
  import tmpos_pkg::*;
#(
  parameter int unsigned FULL_STROKE = FullStrokeDef
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [2:0]           in_action,
  input  logic [PosW-1:0]      in_target,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           out_drive,
  output logic [PosW-1:0]      out_position,
  output logic                 out_move_done,
  output logic                 out_save_strobe,
  output logic [PosW-1:0]      out_save_value,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CfgIdxW-1:0]   cfg_index,
  input  logic [CfgDataW-1:0]  cfg_data
);

  tmpos_state_t         state_r;
  tmpos_state_t         state_nxt;
  tmpos_result_t        res_r;
  tmpos_result_t        res_nxt;
  logic                 out_valid_r;
  logic [StallW-1:0]    stall_timeout_r;
  logic [PosW-1:0]      endpoint_ext_r;
  logic                 in_xfer;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_xfer   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  tmpos_core #(
    .FULL_STROKE(FULL_STROKE)
  ) u_core (
    .state         (state_r),
    .action        (in_action),
    .target        (in_target),
    .stall_timeout (stall_timeout_r),
    .endpoint_ext  (endpoint_ext_r),
    .state_nxt     (state_nxt),
    .result        (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stall_timeout_r <= StallTimeoutRst;
      endpoint_ext_r  <= EndpointExtRst;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_STALL_TIMEOUT: stall_timeout_r <= cfg_data[StallW-1:0];
        CFG_ENDPOINT_EXT:  endpoint_ext_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.motion   <= MOTION_STOP;
      state_r.position <= '0;
      state_r.goal     <= GoalRst;
      state_r.budget   <= '0;
      state_r.elapsed  <= '0;
      state_r.gap      <= '0;
      out_valid_r      <= 1'b0;
    end else begin
      if (in_xfer) begin
        state_r     <= state_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_drive       = res_r.drive;
  assign out_position    = res_r.position;
  assign out_move_done   = res_r.move_done;
  assign out_save_strobe = res_r.save_strobe;
  assign out_save_value  = res_r.save_value;

  a_done_stops: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_move_done |-> out_drive == MOTION_STOP)
    else $error("move_done with motor still driven");

  a_save_round: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_save_strobe |->
      (out_save_value <= out_position) && (out_position - out_save_value < 16'd100))
    else $error("save value not position rounded down to 100");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> {1'b0, out_position} <= (PosW+1)'(FULL_STROKE))
    else $error("position beyond full stroke");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> out_valid)
    else $error("accepted item produced no result");

endmodule

[src/tmpos_core.sv]
// Next-state and result logic for one item of the timed motor positioner.
// Purely combinational; depends on tmpos_pkg.
module tmpos_core
  import tmpos_pkg::*;
#(
  parameter int unsigned FULL_STROKE = FullStrokeDef
) (
  input  tmpos_state_t        state,
  input  logic [2:0]          action,
  input  logic [PosW-1:0]     target,
  input  logic [StallW-1:0]   stall_timeout,
  input  logic [PosW-1:0]     endpoint_ext,
  output tmpos_state_t        state_nxt,
  output tmpos_result_t       result
);

  localparam logic [PosW-1:0] Stroke = PosW'(FULL_STROKE);

  logic [PosW-1:0]   tgt;
  logic [PosW-1:0]   el_inc;
  logic [PosW-1:0]   gap_inc;
  logic [PosW-1:0]   stall_ext;
  logic              goal_end;
  logic              tgt_end;
  logic [PosW:0]     fwd_sum;
  logic [PosW-1:0]   fwd_pos;
  logic [PosW-1:0]   back_pos;
  logic [PosW-1:0]   halt_pos;
  logic [PosW-1:0]   diff;
  logic              done;
  logic [28:0]       prod;
  logic [9:0]        quot;
  logic [PosW-1:0]   rounded;

  assign tgt       = (target > Stroke) ? Stroke : target;
  assign el_inc    = (state.elapsed == CountMax) ? state.elapsed : state.elapsed + 16'd1;
  assign gap_inc   = (state.gap == CountMax) ? state.gap : state.gap + 16'd1;
  assign stall_ext = {{(PosW-StallW){1'b0}}, stall_timeout};
  assign goal_end  = (state.goal == '0) || (state.goal == Stroke);
  assign tgt_end   = (tgt == '0) || (tgt == Stroke);

  assign fwd_sum   = {1'b0, state.position} + {1'b0, state.elapsed};
  assign fwd_pos   = (fwd_sum > {1'b0, Stroke}) ? Stroke : fwd_sum[PosW-1:0];
  assign back_pos  = (state.elapsed >= state.position) ? '0 :
                     state.position - state.elapsed;
  assign halt_pos  = (state.motion == MOTION_FWD) ? fwd_pos : back_pos;
  assign diff      = (state.position > tgt) ? state.position - tgt : tgt - state.position;

  always_comb begin
    state_nxt = state;
    done      = 1'b0;
    case (action)
      ACT_TICK: begin
        if (state.motion != MOTION_STOP) begin
          state_nxt.elapsed = el_inc;
          state_nxt.gap     = gap_inc;
          if ((el_inc >= state.budget) || (gap_inc > stall_ext)) begin
            if ((gap_inc < stall_ext) && goal_end) begin
              state_nxt.elapsed = '0;
              state_nxt.budget  = endpoint_ext;
            end else begin
              state_nxt.position = state.goal;
              state_nxt.motion   = MOTION_STOP;
              done               = 1'b1;
            end
          end
        end
      end
      ACT_HALL: begin
        state_nxt.gap = '0;
      end
      ACT_MOVE: begin
        state_nxt.goal   = tgt;
        state_nxt.budget = tgt_end ? Stroke : diff;
        if ((state.position < tgt) || (tgt >= Stroke)) begin
          state_nxt.elapsed = '0;
          state_nxt.gap     = '0;
          state_nxt.motion  = MOTION_FWD;
        end else if ((state.position > tgt) || (tgt == '0)) begin
          state_nxt.elapsed = '0;
          state_nxt.gap     = '0;
          state_nxt.motion  = MOTION_BACK;
        end else if (state.motion != MOTION_STOP) begin
          state_nxt.position = halt_pos;
          state_nxt.motion   = MOTION_STOP;
          done               = 1'b1;
        end
      end
      ACT_STOP: begin
        if (state.motion != MOTION_STOP) begin
          state_nxt.position = halt_pos;
          state_nxt.motion   = MOTION_STOP;
          done               = 1'b1;
        end
      end
      ACT_PRESET: begin
        state_nxt.position = tgt;
      end
      default: begin
        state_nxt = state;
      end
    endcase
  end

  // round down to a multiple of 100 by reciprocal multiply
  assign prod    = {13'd0, state_nxt.position} * {16'd0, Div100Mul};
  assign quot    = prod[Div100Shift +: 10];
  assign rounded = {quot, 6'd0} + {1'b0, quot, 5'd0} + {4'd0, quot, 2'd0};

  always_comb begin
    result.drive       = state_nxt.motion;
    result.position    = state_nxt.position;
    result.move_done   = done;
    result.save_strobe = done;
    result.save_value  = done ? rounded : '0;
  end

endmodule
